// File: sv/sse_pkg.sv
// Shared types for the shell sort engine.
package sse_pkg;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_GAP,
		ST_PASS,
		ST_RD_HI,
		ST_RD_LO,
		ST_CMP,
		ST_SWAP,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} sse_state_t;

endpackage

// File: sv/sse_key_ram.sv
// Key store: one write port, one read port with registered read data.
module sse_key_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/shell_sort_engine.sv
// Shell sort engine top level: key loading, gapped insertion sequencer and sorted readout.
//
// The block collects a run of signed keys, one per input transaction, until the
// transaction with tlast set closes the run; up to MAX_KEYS keys are kept and any
// further keys of the run (the closing one included) are dropped, though the
// closing key still starts the sort. The stored keys are then Shell-sorted in
// place with gaps of count/2, count/4, ... 1, using a single compare/swap unit
// that works through a one-write, one-read key memory. The input stays ready while
// keys load. The sort opens with the ST_GAP setup state. A pass visits ST_PASS per
// outer position and once more to close; a compare steps through ST_RD_HI,
// ST_RD_LO and ST_CMP, plus ST_SWAP on a swap, all set by the single memory read port.
// Readout steps through ST_EMIT_RD, ST_EMIT_LD and ST_EMIT_WAIT per key, with tlast
// marking the largest key, and waits for the sink to take each key. The input is
// not ready from the closing key until the last sorted key has been taken.
module shell_sort_engine #(
	parameter int MAX_KEYS = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave side
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((KEY_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // [KEY_BITS-1:0] key_value
	input  logic                                  s_axis_tlast,  // is_final
	// master side
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((KEY_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,  // [KEY_BITS-1:0] sorted_key
	output logic                                  m_axis_tlast   // run_end
);

	import sse_pkg::*;

	localparam int DATA_W = ((KEY_BITS + 7) / 8) * 8;
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);
	localparam int IDX_W  = $clog2(MAX_KEYS);

	// Control state
	sse_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;   // stored keys
	logic [CNT_W-1:0]  gap_q, gap_d;       // current gap
	logic [CNT_W-1:0]  outer_q, outer_d;   // outer position of the pass
	logic [CNT_W-1:0]  walk_q, walk_d;     // walk position; readout index during emit
	logic              out_valid_q, out_valid_d;

	// Payload
	logic [KEY_BITS-1:0] hi_q, hi_d;       // later key of the pair under compare
	logic [KEY_BITS-1:0] out_key_q, out_key_d;
	logic                out_last_q, out_last_d;

	// Memory port
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;

	logic [CNT_W-1:0]    hi_addr;
	logic                hi_less;

	sse_key_ram #(
		.DEPTH (MAX_KEYS),
		.WIDTH (KEY_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign hi_addr = walk_q + gap_q;
	// ram_rdata holds the earlier key during ST_CMP
	assign hi_less = $signed(hi_q) < $signed(ram_rdata);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		gap_d       = gap_q;
		outer_d     = outer_q;
		walk_d      = walk_q;
		out_valid_d = out_valid_q;
		hi_d        = hi_q;
		out_key_d   = out_key_q;
		out_last_d  = out_last_q;
		ram_we      = 1'b0;
		ram_waddr   = count_q[IDX_W-1:0];
		ram_wdata   = s_axis_tdata[KEY_BITS-1:0];
		ram_raddr   = walk_q[IDX_W-1:0];
		s_axis_tready = 1'b0;

		case (state_q)
			ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					// keys past capacity are dropped
					if (count_q < CNT_W'(MAX_KEYS)) begin
						ram_we  = 1'b1;
						count_d = count_q + 1'b1;
					end
					if (s_axis_tlast) begin
						state_d = ST_GAP;
					end
				end
			end
			ST_GAP: begin
				gap_d   = count_q >> 1;
				outer_d = count_q >> 1;
				walk_d  = '0;
				if ((count_q >> 1) == '0) begin
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_PASS;
				end
			end
			ST_PASS: begin
				if (outer_q >= count_q) begin
					// pass done: halve the gap
					if ((gap_q >> 1) == '0) begin
						walk_d  = '0;
						state_d = ST_EMIT_RD;
					end else begin
						gap_d   = gap_q >> 1;
						outer_d = gap_q >> 1;
					end
				end else begin
					walk_d  = outer_q - gap_q;
					state_d = ST_RD_HI;
				end
			end
			ST_RD_HI: begin
				ram_raddr = hi_addr[IDX_W-1:0];
				state_d   = ST_RD_LO;
			end
			ST_RD_LO: begin
				ram_raddr = walk_q[IDX_W-1:0];
				hi_d      = ram_rdata;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				if (hi_less) begin
					// earlier key moves up; later key written back in ST_SWAP
					ram_we    = 1'b1;
					ram_waddr = hi_addr[IDX_W-1:0];
					ram_wdata = ram_rdata;
					state_d   = ST_SWAP;
				end else begin
					outer_d = outer_q + 1'b1;
					state_d = ST_PASS;
				end
			end
			ST_SWAP: begin
				ram_we    = 1'b1;
				ram_waddr = walk_q[IDX_W-1:0];
				ram_wdata = hi_q;
				if (walk_q < gap_q) begin
					outer_d = outer_q + 1'b1;
					state_d = ST_PASS;
				end else begin
					walk_d  = walk_q - gap_q;
					state_d = ST_RD_HI;
				end
			end
			ST_EMIT_RD: begin
				ram_raddr = walk_q[IDX_W-1:0];
				state_d   = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				out_key_d   = ram_rdata;
				out_last_d  = (walk_q + 1'b1) == count_q;
				out_valid_d = 1'b1;
				state_d     = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (m_axis_tready) begin
					out_valid_d = 1'b0;
					if (out_last_q) begin
						count_d = '0;
						gap_d   = '0;
						outer_d = '0;
						walk_d  = '0;
						state_d = ST_LOAD;
					end else begin
						walk_d  = walk_q + 1'b1;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			gap_q       <= '0;
			outer_q     <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			gap_q       <= gap_d;
			outer_q     <= outer_d;
			walk_q      <= walk_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		hi_q       <= hi_d;
		out_key_q  <= out_key_d;
		out_last_q <= out_last_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_W'(out_key_q);
	assign m_axis_tlast  = out_last_q;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the shell sort engine: sorted-run prediction and stream checks.
//
// Runs of signed keys go in on the slave stream, each closed by tlast. A local
// Shell sort with halving gaps predicts every sorted run; the master stream is
// checked key by key, with tlast, against the oldest predicted key.
module tb_top;

	localparam int KEY_BITS    = 32;
	localparam int MAX_KEYS    = 64;
	localparam int DATA_W      = ((KEY_BITS + 7) / 8) * 8;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 60;
	localparam int CYCLE_LIMIT = 1000000;

	typedef logic signed [KEY_BITS-1:0] key_t;

	typedef struct {
		key_t key;
		logic last;
	} sorted_key_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_SLOW
	} rx_pattern_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;   // [KEY_BITS-1:0] key_value
	logic              s_axis_tlast = 1'b0; // is_final
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;        // [KEY_BITS-1:0] sorted_key
	logic              m_axis_tlast;        // run_end

	key_t        run_keys[$];   // keys kept so far in the open run
	sorted_key_t sorted_due[$]; // predicted output keys, oldest first
	sorted_key_t due_item;

	int errors       = 0;
	int keys_sent    = 0;
	int keys_dropped = 0;
	int runs_closed  = 0;
	int results_seen = 0;
	int cycle_count  = 0;
	int burst_left   = 0;

	logic        hold_req  = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;
	rx_pattern_t rx_mode   = RX_OPEN;
	int          mode_left = 0;

	shell_sort_engine #(
		.MAX_KEYS(MAX_KEYS),
		.KEY_BITS(KEY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d keys still due", $time, cycle_count,
				sorted_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stall patterns, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen     <= hold_req;
			hold_left     <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   <= rx_pattern_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(16, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
				RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
				default:   m_axis_tready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// Output check: every transaction against the oldest predicted key.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (sorted_due.size() == 0) begin
				$display("%0t: unexpected transaction: expected none, actual key=%0d last=%0b",
					$time, $signed(m_axis_tdata[KEY_BITS-1:0]), m_axis_tlast);
				errors++;
			end else begin
				due_item = sorted_due.pop_front();
				results_seen++;
				if (m_axis_tdata[KEY_BITS-1:0] !== due_item.key) begin
					$display("%0t: sorted_key mismatch: expected %0d, actual %0d", $time,
						due_item.key, $signed(m_axis_tdata[KEY_BITS-1:0]));
					errors++;
				end
				if (m_axis_tlast !== due_item.last) begin
					$display("%0t: run_end mismatch: expected %0b, actual %0b", $time,
						due_item.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// Predictor: keep up to MAX_KEYS keys; a closing key sorts and emits the run.
	task automatic accept_key(input key_t k, input logic fin);
		key_t work[MAX_KEYS];
		key_t tmp;
		int   n;
		int   gap;
		int   walk;
		if (run_keys.size() < MAX_KEYS)
			run_keys.push_back(k);
		else
			keys_dropped++;
		if (fin) begin
			n = run_keys.size();
			for (int i = 0; i < n; i++)
				work[i] = run_keys[i];
			// gapped insertion passes, gaps n/2, n/4, ... 1; equal keys stay put
			for (gap = n / 2; gap > 0; gap = gap / 2) begin
				for (int outer = gap; outer < n; outer++) begin
					walk = outer - gap;
					while (walk >= 0 && work[walk + gap] < work[walk]) begin
						tmp               = work[walk + gap];
						work[walk + gap]  = work[walk];
						work[walk]        = tmp;
						walk              = walk - gap;
					end
				end
			end
			for (int i = 0; i < n; i++)
				sorted_due.push_back('{key: work[i], last: (i == n - 1)});
			run_keys.delete();
			runs_closed++;
		end
	endtask

	// Send one key; bursts of random length separated by random gaps.
	task automatic push_key(input key_t k, input logic fin);
		s_axis_tdata  <= DATA_W'($unsigned(k));
		s_axis_tlast  <= fin;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		accept_key(k, fin);
		keys_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	// Drop valid, then wait until every due key is seen.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sorted_due.size() != 0) @(posedge clk);
	endtask

	function automatic key_t random_key();
		case ($urandom_range(0, 4))
			0:       return key_t'($urandom_range(0, 7)) - 3;   // many equal keys
			1:       return {1'b1, {(KEY_BITS - 1){1'b0}}} + key_t'($urandom_range(0, 3));
			2:       return {1'b0, {(KEY_BITS - 1){1'b1}}} - key_t'($urandom_range(0, 3));
			default: return key_t'($urandom);
		endcase
	endfunction

	task automatic send_random_run(input int len);
		for (int i = 0; i < len; i++)
			push_key(random_key(), i == len - 1);
	endtask

	// --- tests -------------------------------------------------------------

	task automatic test_single_key();
		push_key(-5, 1'b1);
	endtask

	task automatic test_extremes();
		key_t vals[9];
		vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh8000_0001, 32'sh7FFF_FFFE,
			32'shAAAA_AAAA, 32'sh5555_5555};
		foreach (vals[i])
			push_key(vals[i], i == 8);
	endtask

	task automatic test_order_cases();
		// descending run, then a run of equal keys
		for (int i = 0; i < 5; i++)
			push_key(key_t'(40 - 10 * i), i == 4);
		for (int i = 0; i < 4; i++)
			push_key(key_t'(-7), i == 3);
	endtask

	task automatic test_capacity();
		// 65 keys: the store fills and the closing key is dropped but still sorts
		send_random_run(MAX_KEYS + 1);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_req <= ~hold_req;
		send_random_run(6);
		send_random_run(6);
		wait_drained();
	endtask

	task automatic test_random_runs();
		int total;
		total = 0;
		while (total < 12) begin
			int len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
			send_random_run(len);
			total += len;
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_key();
		test_extremes();
		test_order_cases();
		test_capacity();
		test_backpressure();
		test_random_runs();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d runs from %0d keys (%0d past capacity), %0d sorted keys checked.",
			runs_closed, keys_sent, keys_dropped, results_seen);
		$display("Included extremes, equal keys, a full store and long sink back-pressure.");
		if (errors == 0 && sorted_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d keys never seen", errors, sorted_due.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
